/* rtl/core/oofq_pkg.sv */
package oofq_pkg;

   // default geometry
   localparam int SLOTS_DEFAULT           = 64;
   localparam int MAX_FRAME_BYTES_DEFAULT = 255;

   // fixed field widths
   localparam int LEN_W  = 8;
   localparam int SEQ_W  = 16;
   localparam int WORD_W = 64;

   // operation codes
   localparam logic [1:0] OP_PUSH  = 2'd0;
   localparam logic [1:0] OP_POP   = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;

   // result status codes
   localparam logic [1:0] ST_FRAME_DATA = 2'd0;
   localparam logic [1:0] ST_EMPTY      = 2'd1;
   localparam logic [1:0] ST_DISCARDED  = 2'd2;

   // request item
   typedef struct packed {
      logic [1:0]       op;
      logic [7:0]       data_byte;
      logic             end_of_frame;
      logic [LEN_W-1:0] reader_cap;
   } req_type;

   // result item
   typedef struct packed {
      logic [1:0]        status;
      logic [WORD_W-1:0] data_word;
      logic [3:0]        bytes_valid;
      logic [LEN_W-1:0]  frame_length;
      logic [SEQ_W-1:0]  sequence_res;
      logic              last_word;
   } rsp_type;

endpackage

/* rtl/core/oofq_data_mem.sv */
module oofq_data_mem #(
   parameter int DEPTH  = 2048,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [ADDR_W-1:0]         wr_addr,
   input  logic [2:0]                wr_lane,
   input  logic [7:0]                wr_byte,
   input  logic                      rd_en,
   input  logic [ADDR_W-1:0]         rd_addr,
   output logic [oofq_pkg::WORD_W-1:0] rd_data
);

   logic [oofq_pkg::WORD_W-1:0] mem_ff [DEPTH];
   logic [oofq_pkg::WORD_W-1:0] rd_data_ff;

   // byte lane write
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr][{wr_lane, 3'b000} +: 8] <= wr_byte;
      end
   end

   // registered read, held while not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/oofq_meta_mem.sv */
module oofq_meta_mem #(
   parameter int SLOTS  = 64,
   parameter int SLOT_W = $clog2(SLOTS)
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [SLOT_W-1:0]          wr_addr,
   input  logic [oofq_pkg::LEN_W-1:0] wr_len,
   input  logic [oofq_pkg::SEQ_W-1:0] wr_seq,
   input  logic                       rd_en,
   input  logic [SLOT_W-1:0]          rd_addr,
   output logic [oofq_pkg::LEN_W-1:0] rd_len,
   output logic [oofq_pkg::SEQ_W-1:0] rd_seq
);

   logic [oofq_pkg::LEN_W-1:0] len_mem_ff [SLOTS];
   logic [oofq_pkg::SEQ_W-1:0] seq_mem_ff [SLOTS];
   logic [oofq_pkg::LEN_W-1:0] rd_len_ff;
   logic [oofq_pkg::SEQ_W-1:0] rd_seq_ff;

   // commit writes length and sequence together
   always_ff @(posedge clock) begin
      if (wr_en) begin
         len_mem_ff[wr_addr] <= wr_len;
         seq_mem_ff[wr_addr] <= wr_seq;
      end
   end

   // registered read of the tail slot
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_len_ff <= len_mem_ff[rd_addr];
         rd_seq_ff <= seq_mem_ff[rd_addr];
      end
   end

   assign rd_len = rd_len_ff;
   assign rd_seq = rd_seq_ff;

endmodule

/* rtl/core/overwrite_oldest_frame_queue.sv */
// Overwrite-oldest frame queue.
// Request channel (req_valid/req_ready/req_item) carries push, pop and clear
// items; result channel (rsp_valid/rsp_ready/rsp_item) returns pop results.
// A push or clear item gives no result, so pushed bytes stream in at one
// per cycle while no pop is in progress. A pop is accepted, reads the tail
// slot's length, sequence and first word from the memories in that cycle,
// and then, while the receiver does not stall, moves one 64-bit word per
// cycle out of the data memory read port into the output register:
// ceil(length/8) words, or one discarded result if the length exceeds the
// reader cap. An empty pop gives one empty result. The next item is taken
// once the final result of a pop is loaded. When the receiver stalls, the
// output register holds its item and the data memory read register holds
// the next word, so the word stream pauses without loss. Reset clears head,
// tail, write offset and sequence counter; frame memories are not cleared,
// only committed slots are read; bytes past the frame length are masked to zero.
module overwrite_oldest_frame_queue #(
   parameter int SLOTS           = oofq_pkg::SLOTS_DEFAULT,
   parameter int MAX_FRAME_BYTES = oofq_pkg::MAX_FRAME_BYTES_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  oofq_pkg::req_type req_item,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output oofq_pkg::rsp_type rsp_item
);

   localparam int WORDS  = (MAX_FRAME_BYTES + 7) / 8;
   localparam int DEPTH  = SLOTS * WORDS;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int SLOT_W = $clog2(SLOTS);
   localparam int LEN_W  = oofq_pkg::LEN_W;
   localparam int SEQ_W  = oofq_pkg::SEQ_W;

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_DATA  = 2'd1;
   localparam logic [1:0] S_EMPTY = 2'd2;

   logic [1:0]        state_ff, state_in;
   logic [SLOT_W-1:0] head_ff, head_in;
   logic [SLOT_W-1:0] tail_ff, tail_in;
   logic [LEN_W-1:0]  off_ff, off_in;
   logic [SEQ_W-1:0]  seq_ff, seq_in;
   logic [LEN_W-1:0]  cap_ff, cap_in;
   logic [LEN_W-1:0]  remain_ff, remain_in;
   logic              first_ff, first_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic              rsp_valid_ff, rsp_valid_in;
   oofq_pkg::rsp_type rsp_ff, rsp_in;

   logic              accept;
   logic              slot_free;
   logic              is_empty;
   logic [SLOT_W-1:0] head_next;
   logic [SLOT_W-1:0] tail_next;
   logic [SLOT_W-1:0] tail_after_drop;
   logic              byte_fits;
   logic [LEN_W-1:0]  off_inc;

   logic              data_wr_en;
   logic [ADDR_W-1:0] data_wr_addr;
   logic              data_rd_en;
   logic [ADDR_W-1:0] data_rd_addr;
   logic [ADDR_W-1:0] tail_base;
   logic [oofq_pkg::WORD_W-1:0] rd_word;
   logic [oofq_pkg::WORD_W-1:0] word_masked;

   logic              meta_wr_en;
   logic              meta_rd_en;
   logic [LEN_W-1:0]  rd_len;
   logic [SEQ_W-1:0]  rd_seq;

   logic [LEN_W-1:0]  remain;
   logic              last_now;
   logic              too_long;
   logic [3:0]        bytes_valid;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign is_empty  = (head_ff == tail_ff);

   // ring pointer increments
   assign head_next       = (head_ff == SLOT_W'(SLOTS - 1)) ? '0 : head_ff + 1'b1;
   assign tail_next       = (tail_ff == SLOT_W'(SLOTS - 1)) ? '0 : tail_ff + 1'b1;
   assign tail_after_drop = tail_next;

   // push path into the head slot
   assign byte_fits    = (off_ff < LEN_W'(MAX_FRAME_BYTES));
   assign off_inc      = byte_fits ? off_ff + 1'b1 : off_ff;
   assign data_wr_en   = accept && (req_item.op == oofq_pkg::OP_PUSH) && byte_fits;
   assign data_wr_addr = ADDR_W'(head_ff * WORDS + (off_ff >> 3));
   assign meta_wr_en   = accept && (req_item.op == oofq_pkg::OP_PUSH)
                         && req_item.end_of_frame;

   // pop reads: first word at accept, then one word per advance
   assign tail_base    = ADDR_W'(tail_ff * WORDS);
   assign meta_rd_en   = accept && (req_item.op == oofq_pkg::OP_POP) && !is_empty;

   // current word of the frame being emitted
   assign remain      = first_ff ? rd_len : remain_ff;
   assign last_now    = (remain <= LEN_W'(8));
   assign too_long    = (rd_len > cap_ff);
   assign bytes_valid = last_now ? remain[3:0] : 4'd8;

   assign data_rd_en   = meta_rd_en
                         || ((state_ff == S_DATA) && slot_free && !last_now && !too_long);
   assign data_rd_addr = (state_ff == S_IDLE) ? tail_base : addr_ff + 1'b1;

   // zero the byte lanes past the frame end
   always_comb begin
      for (int i = 0; i < 8; i++) begin
         word_masked[i*8 +: 8] = (4'(i) < bytes_valid) ? rd_word[i*8 +: 8] : 8'h00;
      end
   end

   // sequencer and pointer updates
   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      off_in       = off_ff;
      seq_in       = seq_ff;
      cap_in       = cap_ff;
      remain_in    = remain_ff;
      first_in     = first_ff;
      addr_in      = addr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_item.op)
                  oofq_pkg::OP_PUSH: begin
                     if (req_item.end_of_frame) begin
                        off_in  = '0;
                        seq_in  = seq_ff + 1'b1;
                        head_in = head_next;
                        if (head_next == tail_ff) begin
                           tail_in = tail_after_drop;
                        end
                     end else begin
                        off_in = off_inc;
                     end
                  end
                  oofq_pkg::OP_POP: begin
                     cap_in = req_item.reader_cap;
                     if (is_empty) begin
                        state_in = S_EMPTY;
                     end else begin
                        state_in = S_DATA;
                        first_in = 1'b1;
                        addr_in  = tail_base;
                        tail_in  = tail_next;
                     end
                  end
                  oofq_pkg::OP_CLEAR: begin
                     head_in = '0;
                     tail_in = '0;
                     off_in  = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_DATA: begin
            if (slot_free) begin
               rsp_valid_in        = 1'b1;
               rsp_in.frame_length = rd_len;
               rsp_in.sequence_res = rd_seq;
               if (too_long) begin
                  rsp_in.status      = oofq_pkg::ST_DISCARDED;
                  rsp_in.data_word   = '0;
                  rsp_in.bytes_valid = 4'd0;
                  rsp_in.last_word   = 1'b1;
                  state_in           = S_IDLE;
               end else begin
                  rsp_in.status      = oofq_pkg::ST_FRAME_DATA;
                  rsp_in.data_word   = word_masked;
                  rsp_in.bytes_valid = bytes_valid;
                  rsp_in.last_word   = last_now;
                  if (last_now) begin
                     state_in = S_IDLE;
                  end else begin
                     remain_in = remain - LEN_W'(8);
                     first_in  = 1'b0;
                     addr_in   = addr_ff + 1'b1;
                  end
               end
            end
         end
         S_EMPTY: begin
            if (slot_free) begin
               rsp_valid_in        = 1'b1;
               rsp_in.status       = oofq_pkg::ST_EMPTY;
               rsp_in.data_word    = '0;
               rsp_in.bytes_valid  = 4'd0;
               rsp_in.frame_length = '0;
               rsp_in.sequence_res = '0;
               rsp_in.last_word    = 1'b1;
               state_in            = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         off_ff       <= '0;
         seq_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         off_ff       <= off_in;
         seq_ff       <= seq_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cap_ff    <= cap_in;
      remain_ff <= remain_in;
      first_ff  <= first_in;
      addr_ff   <= addr_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   // frame byte storage
   oofq_data_mem #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_data_mem (
      .clock   (clock),
      .wr_en   (data_wr_en),
      .wr_addr (data_wr_addr),
      .wr_lane (off_ff[2:0]),
      .wr_byte (req_item.data_byte),
      .rd_en   (data_rd_en),
      .rd_addr (data_rd_addr),
      .rd_data (rd_word)
   );

   // per-slot length and sequence
   oofq_meta_mem #(
      .SLOTS  (SLOTS),
      .SLOT_W (SLOT_W)
   ) u_meta_mem (
      .clock   (clock),
      .wr_en   (meta_wr_en),
      .wr_addr (head_ff),
      .wr_len  (off_inc),
      .wr_seq  (seq_ff),
      .rd_en   (meta_rd_en),
      .rd_addr (tail_ff),
      .rd_len  (rd_len),
      .rd_seq  (rd_seq)
   );

endmodule
